>>> rtl/rpp_pkg.sv
// Shared types and constants for the RIP packet parser.
`default_nettype none
package rpp_pkg;

	// Byte offsets in the packet (fixed 20-byte IP header, 8-byte UDP header)
	localparam int unsigned LEN_HI_POS   = 2;
	localparam int unsigned LEN_LO_POS   = 3;
	localparam int unsigned CMD_POS      = 28;
	localparam int unsigned VER_POS      = 29;
	localparam int unsigned ZERO_HI_POS  = 30;
	localparam int unsigned ZERO_LO_POS  = 31;
	localparam int unsigned ENTRY_POS    = 32;
	localparam int unsigned ENTRY_BYTES  = 20;

	localparam logic [7:0] CMD_REQUEST  = 8'd1;
	localparam logic [7:0] CMD_RESPONSE = 8'd2;
	localparam logic [7:0] RIP_VERSION  = 8'd2;
	localparam logic [15:0] FAMILY_IP   = 16'd2;
	localparam logic [31:0] METRIC_MAX  = 32'd16;

	// Error codes carried in the summary item
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_LENGTH   = 3'd1;
	localparam logic [2:0] ERR_HEADER   = 3'd2;
	localparam logic [2:0] ERR_FAMILY   = 3'd3;
	localparam logic [2:0] ERR_METRIC   = 3'd4;
	localparam logic [2:0] ERR_MASK     = 3'd5;
	localparam logic [2:0] ERR_TOO_MANY = 3'd6;
	localparam logic [2:0] ERR_SHORT    = 3'd7;

	localparam logic KIND_ROUTE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Result queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic        record_kind;
		logic [31:0] route_address;
		logic [31:0] route_mask;
		logic [31:0] route_next_hop;
		logic [31:0] route_metric;
		logic [7:0]  packet_command;
		logic [4:0]  entry_total;
		logic [2:0]  error_code;
		logic        is_last;
	} record_t;

	// Up to two items produced by one packet byte
	typedef struct packed {
		logic    route_push;
		logic    sum_push;
		record_t route_rec;
		record_t sum_rec;
	} push_t;

endpackage
`default_nettype wire

>>> rtl/rpp_if.sv
// Valid/ready channel interfaces for packet bytes and parser items.
`default_nettype none
interface rpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source(output valid, output data_byte, output end_of_packet, input ready);
	modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface rpp_out_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [31:0] route_address;
	logic [31:0] route_mask;
	logic [31:0] route_next_hop;
	logic [31:0] route_metric;
	logic [7:0]  packet_command;
	logic [4:0]  entry_total;
	logic [2:0]  error_code;
	logic        is_last;

	modport source(output valid, output record_kind, output route_address,
		output route_mask, output route_next_hop, output route_metric,
		output packet_command, output entry_total, output error_code,
		output is_last, input ready);
	modport sink(input valid, input record_kind, input route_address,
		input route_mask, input route_next_hop, input route_metric,
		input packet_command, input entry_total, input error_code,
		input is_last, output ready);
endinterface
`default_nettype wire

>>> rtl/rpp_parse.sv
// Byte-wise packet state, entry checks and item construction.
`default_nettype none
module rpp_parse #(
	parameter int unsigned MAX_ENTRIES = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          end_of_packet,
	output rpp_pkg::push_t     push
);
	import rpp_pkg::*;

	logic [15:0] byte_position_q, byte_position_d;
	logic [15:0] declared_length_q, declared_length_d;
	logic [7:0]  command_q, command_d;
	logic        header_fault_q, header_fault_d;
	logic [4:0]  entry_idx_q, entry_idx_d;
	logic [31:0] family_tag_q, family_tag_d;
	logic [31:0] address_q, address_d;
	logic [31:0] mask_q, mask_d;
	logic [31:0] next_hop_q, next_hop_d;
	logic [31:0] metric_q, metric_d;
	logic [4:0]  entries_q, entries_d;
	logic [2:0]  first_error_q, first_error_d;

	logic [16:0] received;
	logic [2:0]  entry_err;
	logic [2:0]  sum_code;
	logic [31:0] mask_inv;
	logic [31:0] metric_next;
	logic        fam_ok;
	logic        route_push;
	logic        sum_push;
	record_t     route_rec;
	record_t     sum_rec;

	// Metric word with the current byte shifted in (complete on the last entry byte)
	assign metric_next = {metric_q[23:0], data_byte};

	// Entry check on the completed words
	always_comb begin
		mask_inv = ~mask_q;
		fam_ok = (command_q == CMD_RESPONSE && family_tag_q[31:16] == FAMILY_IP) ||
			(command_q == CMD_REQUEST && family_tag_q[31:16] == 16'd0);
		if (!fam_ok || family_tag_q[15:0] != 16'd0) begin
			entry_err = ERR_FAMILY;
		end else if (metric_next == 32'd0 || metric_next > METRIC_MAX) begin
			entry_err = ERR_METRIC;
		end else if ((mask_inv & (mask_inv + 32'd1)) != 32'd0) begin
			entry_err = ERR_MASK;
		end else begin
			entry_err = ERR_NONE;
		end
	end

	always_comb begin
		byte_position_d   = byte_position_q;
		declared_length_d = declared_length_q;
		command_d         = command_q;
		header_fault_d    = header_fault_q;
		entry_idx_d       = entry_idx_q;
		family_tag_d      = family_tag_q;
		address_d         = address_q;
		mask_d            = mask_q;
		next_hop_d        = next_hop_q;
		metric_d          = metric_q;
		entries_d         = entries_q;
		first_error_d     = first_error_q;
		route_push        = 1'b0;
		sum_push          = 1'b0;

		if (byte_position_q == 16'(LEN_HI_POS)) begin
			declared_length_d[15:8] = data_byte;
		end else if (byte_position_q == 16'(LEN_LO_POS)) begin
			declared_length_d[7:0] = data_byte;
		end else if (byte_position_q == 16'(CMD_POS)) begin
			command_d = data_byte;
			if (data_byte != CMD_REQUEST && data_byte != CMD_RESPONSE) begin
				header_fault_d = 1'b1;
			end
		end else if (byte_position_q == 16'(VER_POS)) begin
			if (data_byte != RIP_VERSION) begin
				header_fault_d = 1'b1;
			end
		end else if (byte_position_q == 16'(ZERO_HI_POS) ||
				byte_position_q == 16'(ZERO_LO_POS)) begin
			if (data_byte != 8'd0) begin
				header_fault_d = 1'b1;
			end
			if (byte_position_q == 16'(ZERO_LO_POS) && header_fault_d &&
					first_error_d == ERR_NONE) begin
				first_error_d = ERR_HEADER;
			end
		end else if (byte_position_q >= 16'(ENTRY_POS)) begin
			if (entry_idx_q < 5'd4) begin
				family_tag_d = {family_tag_q[23:0], data_byte};
			end else if (entry_idx_q < 5'd8) begin
				address_d = {address_q[23:0], data_byte};
			end else if (entry_idx_q < 5'd12) begin
				mask_d = {mask_q[23:0], data_byte};
			end else if (entry_idx_q < 5'd16) begin
				next_hop_d = {next_hop_q[23:0], data_byte};
			end else begin
				metric_d = metric_next;
			end

			if (entry_idx_q >= 5'(ENTRY_BYTES - 1)) begin
				entry_idx_d = 5'd0;
				if (entries_q >= 5'(MAX_ENTRIES)) begin
					if (first_error_d == ERR_NONE) begin
						first_error_d = ERR_TOO_MANY;
					end
				end else begin
					if (entry_err != ERR_NONE && first_error_d == ERR_NONE) begin
						first_error_d = entry_err;
					end
					entries_d  = entries_q + 5'd1;
					route_push = 1'b1;
				end
			end else begin
				entry_idx_d = entry_idx_q + 5'd1;
			end
		end

		if (byte_position_q != 16'hFFFF) begin
			byte_position_d = byte_position_q + 16'd1;
		end

		sum_push = end_of_packet;
		if (end_of_packet) begin
			byte_position_d   = '0;
			declared_length_d = '0;
			command_d         = '0;
			header_fault_d    = 1'b0;
			entry_idx_d       = '0;
			family_tag_d      = '0;
			address_d         = '0;
			mask_d            = '0;
			next_hop_d        = '0;
			metric_d          = '0;
			entries_d         = '0;
			first_error_d     = ERR_NONE;
		end
	end

	// Summary code: length beats too-short beats the first recorded fault
	assign received = {1'b0, byte_position_q} + 17'd1;

	always_comb begin
		if (received >= 17'(LEN_LO_POS + 1) && {1'b0, declared_length_q} > received &&
				byte_position_q != 16'(LEN_HI_POS)) begin
			sum_code = ERR_LENGTH;
		end else if (byte_position_q == 16'(LEN_LO_POS) &&
				{1'b0, declared_length_q[15:8], data_byte} > received) begin
			sum_code = ERR_LENGTH;
		end else if (received < 17'(ENTRY_POS)) begin
			sum_code = ERR_SHORT;
		end else begin
			sum_code = first_error_q;
			if (byte_position_q == 16'(ZERO_LO_POS) ||
					byte_position_q >= 16'(ENTRY_POS)) begin
				sum_code = first_error_q;
			end
		end
	end

	// First error as it stands after this byte, before the end-of-packet clear
	function automatic logic [2:0] pre_reset_error();
		logic [2:0] e;
		e = first_error_q;
		if (byte_position_q == 16'(ZERO_LO_POS)) begin
			if ((header_fault_q || data_byte != 8'd0) && e == ERR_NONE) begin
				e = ERR_HEADER;
			end
		end else if (byte_position_q >= 16'(ENTRY_POS) &&
				entry_idx_q >= 5'(ENTRY_BYTES - 1) && e == ERR_NONE) begin
			if (entries_q >= 5'(MAX_ENTRIES)) begin
				e = ERR_TOO_MANY;
			end else begin
				e = entry_err;
			end
		end
		return e;
	endfunction

	// Route item: address/mask/next hop are final before the last entry byte
	always_comb begin
		route_rec                = '0;
		route_rec.record_kind    = KIND_ROUTE;
		route_rec.route_address  = address_q;
		route_rec.route_mask     = mask_q;
		route_rec.route_next_hop = next_hop_q;
		route_rec.route_metric   = metric_next;
		route_rec.packet_command = command_q;

		sum_rec                  = '0;
		sum_rec.record_kind      = KIND_SUMMARY;
		sum_rec.packet_command   = (byte_position_q == 16'(CMD_POS)) ? data_byte : command_q;
		sum_rec.entry_total      = entries_q + 5'(route_push);
		sum_rec.is_last          = 1'b1;
		if (sum_code == ERR_LENGTH || sum_code == ERR_SHORT) begin
			sum_rec.error_code = sum_code;
		end else begin
			sum_rec.error_code = pre_reset_error();
		end
	end

	assign push = '{route_push, sum_push, route_rec, sum_rec};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			declared_length_q <= '0;
			command_q         <= '0;
			header_fault_q    <= 1'b0;
			entry_idx_q       <= '0;
			family_tag_q      <= '0;
			address_q         <= '0;
			mask_q            <= '0;
			next_hop_q        <= '0;
			metric_q          <= '0;
			entries_q         <= '0;
			first_error_q     <= ERR_NONE;
		end else if (accept) begin
			byte_position_q   <= byte_position_d;
			declared_length_q <= declared_length_d;
			command_q         <= command_d;
			header_fault_q    <= header_fault_d;
			entry_idx_q       <= entry_idx_d;
			family_tag_q      <= family_tag_d;
			address_q         <= address_d;
			mask_q            <= mask_d;
			next_hop_q        <= next_hop_d;
			metric_q          <= metric_d;
			entries_q         <= entries_d;
			first_error_q     <= first_error_d;
		end
	end

	entry_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_idx_q <= 5'(ENTRY_BYTES - 1))
		else $error("entry byte index out of range");

	route_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && route_push) |-> (byte_position_q >= 16'(ENTRY_POS)))
		else $error("route item outside the entry area");

	clear_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sum_push) |=> (byte_position_q == 16'd0 && entries_q == 5'd0))
		else $error("state not cleared after packet end");

endmodule
`default_nettype wire

>>> rtl/rpp_out_fifo.sv
// Small result queue: takes up to two items per cycle, hands out one.
`default_nettype none
module rpp_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  rpp_pkg::push_t        push,
	output logic                  room,
	output logic                  head_valid,
	input  wire logic             head_pop,
	output rpp_pkg::record_t      head
);
	import rpp_pkg::*;

	record_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 wr0;
	logic                 wr1;
	logic [FIFO_CW-1:0]   n_push;
	logic                 pop;
	record_t              d0;

	assign wr0    = accept && (push.route_push || push.sum_push);
	assign wr1    = accept && push.route_push && push.sum_push;
	assign d0     = push.route_push ? push.route_rec : push.sum_rec;
	assign n_push = FIFO_CW'(wr0) + FIFO_CW'(wr1);
	assign pop    = head_valid && head_pop;

	assign room       = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem[wr_ptr_q] <= d0;
		end
		if (wr1) begin
			mem[wr_ptr_q + FIFO_AW'(1)] <= push.sum_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + n_push - FIFO_CW'(pop);
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != '0) |-> (count_q <= FIFO_CW'(FIFO_DEPTH - 2)))
		else $error("push into full queue");

	count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count out of range");

	ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_AW'(wr_ptr_q - rd_ptr_q) == FIFO_AW'(count_q))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

>>> rtl/rip_packet_parser.sv
// Top level of the RIPv2 packet parser: byte input, route and summary items out.
// Items caused by a byte enter the result queue as the byte is accepted; rec offers the head.
// Throughput: one byte per cycle while ready; a byte yields at most two items (route + summary).
// pkt.ready is high while the 4-entry result queue has two free slots, so it only
// drops when rec is stalled. Reset (arst_n low) clears all parser state and empties the queue.
`default_nettype none
module rip_packet_parser #(
	parameter int unsigned MAX_ENTRIES = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpp_in_if.sink     pkt,
	rpp_out_if.source  rec
);
	import rpp_pkg::*;

	push_t   push;
	record_t head;
	logic    accept;
	logic    room;
	logic    head_valid;

	// A byte is taken whenever the queue can absorb the worst case of two items.
	assign pkt.ready = room;
	assign accept    = pkt.valid && room;

	// Parser: packet position, header checks, entry assembly and checks.
	// All decisions for a byte are made in the cycle it is accepted.
	rpp_parse #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (pkt.data_byte),
		.end_of_packet(pkt.end_of_packet),
		.push         (push)
	);

	// Result queue decouples the output handshake from the byte stream;
	// a route item is written ahead of a summary item from the same byte.
	rpp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.push      (push),
		.room      (room),
		.head_valid(head_valid),
		.head_pop  (rec.ready),
		.head      (head)
	);

	// Drive the output channel from the queue head.
	assign rec.valid          = head_valid;
	assign rec.record_kind    = head.record_kind;
	assign rec.route_address  = head.route_address;
	assign rec.route_mask     = head.route_mask;
	assign rec.route_next_hop = head.route_next_hop;
	assign rec.route_metric   = head.route_metric;
	assign rec.packet_command = head.packet_command;
	assign rec.entry_total    = head.entry_total;
	assign rec.error_code     = head.error_code;
	assign rec.is_last        = head.is_last;

endmodule
`default_nettype wire

>>> tb/rpp_checker.sv
// Scoreboard for the RIP packet parser: mirrors the byte parse and checks every output item.
`timescale 1ns / 1ps
module rpp_checker #(
	parameter int unsigned MAX_ENTRIES = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	rpp_in_if           pkt,
	rpp_out_if          rec,
	output int unsigned fail_count,
	output int unsigned pending
);
	import rpp_pkg::*;

	// mirrored parse state
	logic [15:0] byte_at;
	logic [15:0] declared_len;
	logic [7:0]  rip_cmd;
	logic        header_bad;
	logic [4:0]  entry_idx;
	logic [31:0] fam_tag;
	logic [31:0] addr_acc;
	logic [31:0] mask_acc;
	logic [31:0] hop_acc;
	logic [31:0] metric_acc;
	logic [4:0]  routes_counted;
	logic [2:0]  first_fault;

	record_t records_due[$];
	record_t want;

	task automatic clear_parse();
		byte_at        = '0;
		declared_len   = '0;
		rip_cmd        = '0;
		header_bad     = 1'b0;
		entry_idx      = '0;
		fam_tag        = '0;
		addr_acc       = '0;
		mask_acc       = '0;
		hop_acc        = '0;
		metric_acc     = '0;
		routes_counted = '0;
		first_fault    = ERR_NONE;
	endtask

	task automatic keep_first(input logic [2:0] code);
		if (first_fault == ERR_NONE)
			first_fault = code;
	endtask

	// family/tag, then metric, then mask contiguity
	function automatic logic [2:0] route_fault();
		logic [15:0] fam;
		logic [15:0] tag;
		logic [31:0] inv;
		logic        fam_ok;
		fam    = fam_tag[31:16];
		tag    = fam_tag[15:0];
		inv    = ~mask_acc;
		fam_ok = (rip_cmd == CMD_RESPONSE && fam == FAMILY_IP) ||
			(rip_cmd == CMD_REQUEST && fam == 16'h0);
		if (!fam_ok || tag != 16'h0)
			return ERR_FAMILY;
		if (metric_acc < 32'd1 || metric_acc > METRIC_MAX)
			return ERR_METRIC;
		if ((inv & (inv + 32'd1)) != 32'h0)
			return ERR_MASK;
		return ERR_NONE;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic eop);
		logic [15:0] at;
		logic [16:0] received;
		logic [2:0]  code;
		record_t     r;
		at = byte_at;
		if (at == LEN_HI_POS) begin
			declared_len[15:8] = b;
		end else if (at == LEN_LO_POS) begin
			declared_len[7:0] = b;
		end else if (at == CMD_POS) begin
			rip_cmd = b;
			if (b != CMD_REQUEST && b != CMD_RESPONSE)
				header_bad = 1'b1;
		end else if (at == VER_POS) begin
			if (b != RIP_VERSION)
				header_bad = 1'b1;
		end else if (at == ZERO_HI_POS || at == ZERO_LO_POS) begin
			if (b != 8'h0)
				header_bad = 1'b1;
			if (at == ZERO_LO_POS && header_bad)
				keep_first(ERR_HEADER);
		end else if (at >= ENTRY_POS) begin
			if (entry_idx < 5'd4)
				fam_tag = {fam_tag[23:0], b};
			else if (entry_idx < 5'd8)
				addr_acc = {addr_acc[23:0], b};
			else if (entry_idx < 5'd12)
				mask_acc = {mask_acc[23:0], b};
			else if (entry_idx < 5'd16)
				hop_acc = {hop_acc[23:0], b};
			else
				metric_acc = {metric_acc[23:0], b};
			if (entry_idx == ENTRY_BYTES - 1) begin
				entry_idx = '0;
				if (routes_counted >= MAX_ENTRIES) begin
					// beyond the table limit: no item, no check
					keep_first(ERR_TOO_MANY);
				end else begin
					keep_first(route_fault());
					routes_counted++;
					r                = '0;
					r.record_kind    = KIND_ROUTE;
					r.route_address  = addr_acc;
					r.route_mask     = mask_acc;
					r.route_next_hop = hop_acc;
					r.route_metric   = metric_acc;
					r.packet_command = rip_cmd;
					records_due.push_back(r);
				end
			end else begin
				entry_idx++;
			end
		end
		if (byte_at != 16'hFFFF)
			byte_at++;
		if (eop) begin
			received = {1'b0, at} + 17'd1;
			if (received >= 17'd4 && {1'b0, declared_len} > received)
				code = ERR_LENGTH;
			else if (received < ENTRY_POS)
				code = ERR_SHORT;
			else
				code = first_fault;
			r                = '0;
			r.record_kind    = KIND_SUMMARY;
			r.packet_command = rip_cmd;
			r.entry_total    = routes_counted;
			r.error_code     = code;
			r.is_last        = 1'b1;
			records_due.push_back(r);
			clear_parse();
		end
	endtask

	function automatic void field_check(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$error("%s expected %0h got %0h", name, exp_v, got_v);
		end
	endfunction

	// results first: an item on rec at this edge stems from an earlier byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			records_due.delete();
			fail_count = 0;
		end else begin
			if (rec.valid === 1'b1 && rec.ready === 1'b1) begin
				if (records_due.size() == 0) begin
					fail_count++;
					$error("item with nothing expected, record_kind %0h", rec.record_kind);
				end else begin
					want = records_due.pop_front();
					field_check("record_kind", 32'(want.record_kind), 32'(rec.record_kind));
					field_check("route_address", want.route_address, rec.route_address);
					field_check("route_mask", want.route_mask, rec.route_mask);
					field_check("route_next_hop", want.route_next_hop, rec.route_next_hop);
					field_check("route_metric", want.route_metric, rec.route_metric);
					field_check("packet_command", 32'(want.packet_command),
						32'(rec.packet_command));
					field_check("entry_total", 32'(want.entry_total), 32'(rec.entry_total));
					field_check("error_code", 32'(want.error_code), 32'(rec.error_code));
					field_check("is_last", 32'(want.is_last), 32'(rec.is_last));
				end
			end
			if (pkt.valid === 1'b1 && pkt.ready === 1'b1)
				parse_byte(pkt.data_byte, pkt.end_of_packet);
		end
		pending = records_due.size();
	end

endmodule

>>> tb/rip_packet_parser_tb.sv
// Top of the RIP packet parser testbench: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps
module rip_packet_parser_tb;
	import rpp_pkg::*;

	localparam int unsigned MAX_ENTRIES  = 25;
	localparam int unsigned RAND_BYTES   = 340;   // random part stops once this many bytes went in
	localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off for the back-pressure packet
	localparam int unsigned DRAIN_CYCLES = 8;     // watch for stray items once nothing is pending
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	// fault planted in one route entry
	typedef enum int unsigned {
		FLAW_NONE,
		FLAW_FAMILY,
		FLAW_TAG,
		FLAW_METRIC,
		FLAW_MASK
	} route_flaw_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count = 0;
	int unsigned rand_bytes = 0;
	bit          hold_req = 1'b0;   // asks the drain process for one long stall
	logic [7:0]  frame[$];          // packet under construction, wire order

	rpp_in_if  pkt_ch();
	rpp_out_if rec_ch();

	rip_packet_parser #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt   (pkt_ch),
		.rec   (rec_ch)
	);

	rpp_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt_ch),
		.rec       (rec_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] prefix_mask(input int unsigned ones);
		if (ones == 0)
			return 32'h0;
		return 32'hFFFF_FFFF << (32 - ones);
	endfunction

	task automatic put_word(input logic [31:0] w);
		frame.push_back(w[31:24]);
		frame.push_back(w[23:16]);
		frame.push_back(w[15:8]);
		frame.push_back(w[7:0]);
	endtask

	// random IP and UDP headers, then the four RIP header bytes
	task automatic start_frame(input logic [7:0] cmd, input logic [7:0] ver,
		input logic [15:0] zero_field);
		frame.delete();
		repeat (CMD_POS) frame.push_back(8'($urandom_range(0, 255)));
		frame.push_back(cmd);
		frame.push_back(ver);
		frame.push_back(zero_field[15:8]);
		frame.push_back(zero_field[7:0]);
	endtask

	task automatic set_length(input int unsigned len);
		frame[LEN_HI_POS] = len[15:8];
		frame[LEN_LO_POS] = len[7:0];
	endtask

	task automatic put_entry(input logic [15:0] fam, input logic [15:0] tag,
		input logic [31:0] addr, input logic [31:0] mask, input logic [31:0] hop,
		input logic [31:0] metric);
		put_word({fam, tag});
		put_word(addr);
		put_word(mask);
		put_word(hop);
		put_word(metric);
	endtask

	// a legal entry for the command, with at most one planted fault
	task automatic put_route(input logic [7:0] cmd, input route_flaw_e flaw);
		logic [15:0] fam;
		logic [15:0] tag;
		logic [31:0] mask;
		logic [31:0] metric;
		fam    = (cmd == CMD_RESPONSE) ? FAMILY_IP : 16'h0;
		tag    = 16'h0;
		mask   = prefix_mask($urandom_range(0, 32));
		metric = 32'($urandom_range(1, 16));
		case (flaw)
			FLAW_FAMILY: begin
				if ($urandom_range(0, 1) == 0)
					fam = (cmd == CMD_RESPONSE) ? 16'h0 : FAMILY_IP;
				else
					fam = 16'($urandom_range(0, 65535)) | 16'h0100;
			end
			FLAW_TAG: tag = 16'($urandom_range(1, 65535));
			FLAW_METRIC: begin
				case ($urandom_range(0, 2))
					0: metric = 32'h0;
					1: metric = METRIC_MAX + 32'd1;
					default: metric = $urandom | 32'h100;  // also catches byte-swapped reads
				endcase
			end
			// top bit clear, bottom bit set: never a run of leading ones
			FLAW_MASK: mask = {1'b0, 30'($urandom), 1'b1};
			default: ;
		endcase
		put_entry(fam, tag, $urandom, mask, $urandom, metric);
	endtask

	// offer the frame a byte at a time; steady means no gaps between bytes
	task automatic send_frame(input bit steady);
		int unsigned gap;
		for (int i = 0; i < frame.size(); i++) begin
			gap = steady ? 0 : idle_gap();
			if (gap != 0) begin
				pkt_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pkt_ch.valid         <= 1'b1;
			pkt_ch.data_byte     <= frame[i];
			pkt_ch.end_of_packet <= (i == frame.size() - 1);
			do @(posedge clk); while (pkt_ch.ready !== 1'b1);
			@(negedge clk);
		end
	endtask

	// Mostly well-formed packets with random content; the rest carry one kind
	// of damage: header bytes, faulty entries, trailing partial entry, an
	// overstated length, truncation, or plain noise.
	task automatic rand_packet();
		int unsigned style;
		int unsigned n_routes;
		int unsigned cut;
		logic [7:0]  cmd;
		route_flaw_e flaw;
		style    = $urandom_range(0, 99);
		cmd      = ($urandom_range(0, 1) == 0) ? CMD_REQUEST : CMD_RESPONSE;
		n_routes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
		if (style >= 95) begin
			frame.delete();
			repeat ($urandom_range(1, 90)) frame.push_back(8'($urandom_range(0, 255)));
		end else begin
			start_frame(cmd, RIP_VERSION, 16'h0);
			if (style >= 60 && style < 67)
				frame[CMD_POS + $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
			for (int i = 0; i < n_routes; i++) begin
				flaw = FLAW_NONE;
				if (style >= 67 && style < 82 && $urandom_range(0, 2) == 0)
					flaw = route_flaw_e'($urandom_range(1, 4));
				put_route(cmd, flaw);
			end
			set_length(frame.size());
			if (style >= 82 && style < 87) begin
				repeat ($urandom_range(1, 19)) frame.push_back(8'($urandom_range(0, 255)));
			end else if (style >= 87 && style < 91) begin
				set_length(frame.size() + $urandom_range(1, 300));
			end else if (style >= 91) begin
				cut   = $urandom_range(1, 31);
				frame = frame[0:cut - 1];
			end
		end
		send_frame($urandom_range(0, 3) == 0);
		rand_bytes += frame.size();
	endtask

	// Receiver: random stalls, with long always-ready runs in between. A hold
	// request turns into one long stall so the result queue backs up.
	initial begin : drain_ready
		int unsigned stall_left;
		int unsigned run_left;
		stall_left   = 0;
		run_left     = 0;
		rec_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				rec_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rec_ch.ready <= 1'b1;
				if (run_left != 0) begin
					run_left--;
				end else begin
					stall_left = idle_gap();
					run_left   = ($urandom_range(0, 7) == 0) ?
						$urandom_range(30, 150) : $urandom_range(0, 5);
				end
			end
		end
	end

	initial begin : stimulus
		pkt_ch.valid         = 1'b0;
		pkt_ch.data_byte     = 8'h0;
		pkt_ch.end_of_packet = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed packets ---
		// single byte: too short, length check skipped below four bytes
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		set_length(16'hFFFF);
		frame = frame[0:0];
		send_frame(1'b0);
		// three bytes, huge length: still only too short
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		set_length(16'hFFFF);
		frame = frame[0:2];
		send_frame(1'b0);
		// four bytes, length 0xFFFF: length error
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		set_length(16'hFFFF);
		frame = frame[0:3];
		send_frame(1'b0);
		// header minus one byte
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0);
		set_length(31);
		frame = frame[0:30];
		send_frame(1'b0);
		// bare header, no entries
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		set_length(frame.size());
		send_frame(1'b1);
		// request with field extremes: empty mask, metric 16, then all ones, metric 1
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0);
		put_entry(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, METRIC_MAX);
		put_entry(16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		set_length(frame.size());
		send_frame(1'b0);
		// response with host mask and mixed prefixes
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		put_entry(FAMILY_IP, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'd1);
		put_route(CMD_RESPONSE, FLAW_NONE);
		set_length(frame.size());
		send_frame(1'b0);
		// header faults (bad command, bad version, nonzero zero field); the
		// faulty entries after them must not override the header error
		start_frame(8'h03, RIP_VERSION, 16'h0);
		put_route(CMD_RESPONSE, FLAW_METRIC);
		set_length(frame.size());
		send_frame(1'b0);
		start_frame(CMD_RESPONSE, 8'h01, 16'h0);
		put_route(CMD_RESPONSE, FLAW_MASK);
		set_length(frame.size());
		send_frame(1'b0);
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h8000);
		set_length(frame.size());
		send_frame(1'b0);
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0001);
		set_length(frame.size());
		send_frame(1'b0);
		// entry faults: first one wins, and family/tag outranks metric and mask
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		put_route(CMD_RESPONSE, FLAW_NONE);
		put_entry(16'h0, 16'h0, $urandom, 32'h0000_00FF, $urandom, 32'h0);
		put_route(CMD_RESPONSE, FLAW_METRIC);
		set_length(frame.size());
		send_frame(1'b0);
		// metric outranks mask within one entry
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		put_entry(FAMILY_IP, 16'h0, $urandom, 32'h0000_00FF, $urandom, 32'h0100_0000);
		set_length(frame.size());
		send_frame(1'b0);
		// mask fault alone, then tag fault alone
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0);
		put_route(CMD_REQUEST, FLAW_MASK);
		set_length(frame.size());
		send_frame(1'b0);
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0);
		put_route(CMD_REQUEST, FLAW_TAG);
		set_length(frame.size());
		send_frame(1'b0);
		// request carrying the response family
		start_frame(CMD_REQUEST, RIP_VERSION, 16'h0);
		put_entry(FAMILY_IP, 16'h0, $urandom, 32'hFFFF_FF00, $urandom, 32'd5);
		set_length(frame.size());
		send_frame(1'b0);
		// length error outranks a header fault
		start_frame(8'h00, RIP_VERSION, 16'h0);
		put_route(CMD_RESPONSE, FLAW_NONE);
		set_length(frame.size() + 1);
		send_frame(1'b0);
		// entry beyond the declared length still counts; 19 trailing bytes ignored
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		set_length(frame.size());
		put_route(CMD_RESPONSE, FLAW_NONE);
		repeat (ENTRY_BYTES - 1) frame.push_back(8'($urandom_range(0, 255)));
		send_frame(1'b0);
		// two entries past the table limit: no items for them, too-many error
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		repeat (MAX_ENTRIES + 2) put_route(CMD_RESPONSE, FLAW_NONE);
		set_length(frame.size());
		send_frame(1'b1);
		// back-pressure: receiver holds off while bytes keep coming back to back
		start_frame(CMD_RESPONSE, RIP_VERSION, 16'h0);
		repeat (10) put_route(CMD_RESPONSE, FLAW_NONE);
		set_length(frame.size());
		hold_req = 1'b1;
		send_frame(1'b1);

		// --- random packets ---
		while (rand_bytes < RAND_BYTES)
			rand_packet();
		pkt_ch.valid <= 1'b0;

		// let every expected item arrive, then watch a few more cycles for strays
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/rpp_pkg.sv
rtl/rpp_if.sv
rtl/rpp_parse.sv
rtl/rpp_out_fifo.sv
rtl/rip_packet_parser.sv
tb/rpp_checker.sv
tb/rip_packet_parser_tb.sv
